>>> rtl/ptgb_pkg.sv
`timescale 1ns / 1ps

package ptgb_pkg;

  // Grid size defaults, cells per axis.
  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 128;

  localparam int CoordW  = 20;
  localparam int CellW   = 14;
  localparam int StatusW = 3;
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 6;

  typedef enum logic [StatusW-1:0] {
    ST_BINNED  = 3'd0,
    ST_INVALID = 3'd1,
    ST_NEAR    = 3'd2,
    ST_FAR     = 3'd3,
    ST_OUTSIDE = 3'd4
  } ptgb_status_t;

  typedef enum logic [2:0] {
    REG_ROT_X    = 3'd0,
    REG_ROT_Y    = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_CPM      = 3'd4,
    REG_NEAR     = 3'd5,
    REG_FAR      = 3'd6,
    REG_NONE     = 3'd7
  } ptgb_reg_t;

  typedef struct packed {
    logic [47:0]        rot_x;
    logic [47:0]        rot_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [15:0]        cells_per_meter;
    logic [39:0]        near_clip_sq;
    logic [39:0]        far_clip_sq;
  } ptgb_cfg_t;

  localparam logic [47:0] ROT_X_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_Y_RST = 48'h0000_0000_4000;
  localparam logic [15:0] CPM_RST   = 16'd512;
  localparam logic [39:0] FAR_RST   = 40'hFF_FFFF_FFFF;

endpackage

>>> rtl/ptgb_regs.sv
`timescale 1ns / 1ps

module ptgb_regs import ptgb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready,
  output ptgb_cfg_t           cfg
);

  ptgb_cfg_t cfg_r;
  ptgb_reg_t sel;
  logic      wr_en;

  assign cfg_pready = 1'b1;
  assign sel        = ptgb_reg_t'(cfg_paddr[5:3]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot_x           <= ROT_X_RST;
      cfg_r.rot_y           <= ROT_Y_RST;
      cfg_r.offset_x        <= '0;
      cfg_r.offset_y        <= '0;
      cfg_r.cells_per_meter <= CPM_RST;
      cfg_r.near_clip_sq    <= '0;
      cfg_r.far_clip_sq     <= FAR_RST;
    end else if (wr_en) begin
      case (sel)
        REG_ROT_X:    cfg_r.rot_x           <= cfg_pwdata[47:0];
        REG_ROT_Y:    cfg_r.rot_y           <= cfg_pwdata[47:0];
        REG_OFFSET_X: cfg_r.offset_x        <= $signed(cfg_pwdata[31:0]);
        REG_OFFSET_Y: cfg_r.offset_y        <= $signed(cfg_pwdata[31:0]);
        REG_CPM:      cfg_r.cells_per_meter <= cfg_pwdata[15:0];
        REG_NEAR:     cfg_r.near_clip_sq    <= cfg_pwdata[39:0];
        REG_FAR:      cfg_r.far_clip_sq     <= cfg_pwdata[39:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (sel)
      REG_ROT_X:    cfg_prdata = {16'b0, cfg_r.rot_x};
      REG_ROT_Y:    cfg_prdata = {16'b0, cfg_r.rot_y};
      REG_OFFSET_X: cfg_prdata = {32'b0, cfg_r.offset_x};
      REG_OFFSET_Y: cfg_prdata = {32'b0, cfg_r.offset_y};
      REG_CPM:      cfg_prdata = {48'b0, cfg_r.cells_per_meter};
      REG_NEAR:     cfg_prdata = {24'b0, cfg_r.near_clip_sq};
      REG_FAR:      cfg_prdata = {24'b0, cfg_r.far_clip_sq};
      default:      cfg_prdata = '0;
    endcase
  end

endmodule

>>> rtl/ptgb_pipe.sv
`timescale 1ns / 1ps

module ptgb_pipe import ptgb_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptgb_cfg_t            cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [79:0]          out_tdata,
  output logic [StatusW-1:0]   out_tuser
);

  localparam int PtW = 3 * CoordW;

  // Per-stage enables; a stage loads when it is empty or its successor moves.
  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign en5       = !v5_r || out_tready;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: squares and rotation products.
  logic signed [CoordW-1:0] px, py, pz;
  logic signed [39:0] sq_x_nxt, sq_y_nxt, sq_z_nxt;
  logic [39:0]        sq_x_r, sq_y_r, sq_z_r;
  logic signed [35:0] rx0_r, rx1_r, rx2_r, ry0_r, ry1_r, ry2_r;
  logic [PtW-1:0]     pt1_r;
  logic               pv1_r;

  assign px = $signed(in_tdata[19:0]);
  assign py = $signed(in_tdata[39:20]);
  assign pz = $signed(in_tdata[59:40]);

  assign sq_x_nxt = px * px;
  assign sq_y_nxt = py * py;
  assign sq_z_nxt = pz * pz;

  always_ff @(posedge clk) begin
    if (en1) begin
      sq_x_r <= $unsigned(sq_x_nxt);
      sq_y_r <= $unsigned(sq_y_nxt);
      sq_z_r <= $unsigned(sq_z_nxt);
      rx0_r  <= $signed(cfg.rot_x[15:0])  * px;
      rx1_r  <= $signed(cfg.rot_x[31:16]) * py;
      rx2_r  <= $signed(cfg.rot_x[47:32]) * pz;
      ry0_r  <= $signed(cfg.rot_y[15:0])  * px;
      ry1_r  <= $signed(cfg.rot_y[31:16]) * py;
      ry2_r  <= $signed(cfg.rot_y[47:32]) * pz;
      pt1_r  <= in_tdata[PtW-1:0];
      pv1_r  <= in_tuser;
    end
  end

  // Stage 2: range sum and clip checks, map coordinates in 2^-24 m.
  logic [39:0]        d2;
  logic signed [47:0] acc_x_nxt, acc_y_nxt;
  logic signed [47:0] acc_x_r, acc_y_r;
  ptgb_status_t       st_nxt, st2_r;
  logic [PtW-1:0]     pt2_r;

  assign d2 = sq_x_r + sq_y_r + sq_z_r;

  always_comb begin
    if (!pv1_r) begin
      st_nxt = ST_INVALID;
    end else if (d2 < cfg.near_clip_sq) begin
      st_nxt = ST_NEAR;
    end else if (d2 > cfg.far_clip_sq) begin
      st_nxt = ST_FAR;
    end else begin
      st_nxt = ST_BINNED;
    end
  end

  assign acc_x_nxt = {{12{rx0_r[35]}}, rx0_r} + {{12{rx1_r[35]}}, rx1_r}
                   + {{12{rx2_r[35]}}, rx2_r} + {{2{cfg.offset_x[31]}}, cfg.offset_x, 14'b0};
  assign acc_y_nxt = {{12{ry0_r[35]}}, ry0_r} + {{12{ry1_r[35]}}, ry1_r}
                   + {{12{ry2_r[35]}}, ry2_r} + {{2{cfg.offset_y[31]}}, cfg.offset_y, 14'b0};

  always_ff @(posedge clk) begin
    if (en2) begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      st2_r   <= st_nxt;
      pt2_r   <= pt1_r;
    end
  end

  // Stage 3: scaling multiply split into a low unsigned and a high signed half.
  logic [39:0]        lo_x_r, lo_y_r;
  logic signed [40:0] hi_x_r, hi_y_r;
  ptgb_status_t       st3_r;
  logic [PtW-1:0]     pt3_r;
  logic signed [16:0] cpm_s;

  assign cpm_s = $signed({1'b0, cfg.cells_per_meter});

  always_ff @(posedge clk) begin
    if (en3) begin
      lo_x_r <= 40'(acc_x_r[23:0]) * 40'(cfg.cells_per_meter);
      lo_y_r <= 40'(acc_y_r[23:0]) * 40'(cfg.cells_per_meter);
      hi_x_r <= $signed(acc_x_r[47:24]) * cpm_s;
      hi_y_r <= $signed(acc_y_r[47:24]) * cpm_s;
      st3_r  <= st2_r;
      pt3_r  <= pt2_r;
    end
  end

  // Stage 4: recombine, floor to cells and check the grid bounds.
  logic signed [65:0] prod_x, prod_y;
  logic signed [33:0] gx, gy;
  logic               outside;
  logic [CellW-1:0]   gx4_r, gy4_r;
  ptgb_status_t       st4_r;
  logic [PtW-1:0]     pt4_r;

  assign prod_x = {hi_x_r[40], hi_x_r, 24'b0} + {26'b0, lo_x_r};
  assign prod_y = {hi_y_r[40], hi_y_r, 24'b0} + {26'b0, lo_y_r};
  // Dropping the low 32 bits of a two's-complement value floors it.
  assign gx = prod_x[65:32];
  assign gy = prod_y[65:32];
  assign outside = gx[33] || (gx[32:0] >= 33'(GRID_WIDTH))
                || gy[33] || (gy[32:0] >= 33'(GRID_HEIGHT));

  always_ff @(posedge clk) begin
    if (en4) begin
      gx4_r <= gx[CellW-1:0];
      gy4_r <= gy[CellW-1:0];
      st4_r <= (st3_r == ST_BINNED && outside) ? ST_OUTSIDE : st3_r;
      pt4_r <= pt3_r;
    end
  end

  // Stage 5: row-major index and output register.
  logic [27:0]      cell_full;
  logic [CellW-1:0] cell5_r;
  ptgb_status_t     st5_r;
  logic [PtW-1:0]   pt5_r;

  assign cell_full = 28'(gy4_r) * 28'(GRID_WIDTH) + 28'(gx4_r);

  always_ff @(posedge clk) begin
    if (en5) begin
      st5_r   <= st4_r;
      cell5_r <= (st4_r == ST_BINNED) ? cell_full[CellW-1:0] : '0;
      pt5_r   <= (st4_r == ST_BINNED) ? pt4_r : '0;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tuser  = st5_r;
  assign out_tdata  = {6'b0, pt5_r, cell5_r};

endmodule

>>> rtl/point_to_grid_binning_top.sv
// Point-to-grid binning: five register stages; out_tvalid is the valid bit of the last stage.
// Throughput is one request per cycle while out_tready holds; the pipeline compresses bubbles on stall.
// The map scaling multiply is split over stages three and four as two partial products.
// Reset is synchronous, active low: it empties the pipeline and loads register defaults.
`timescale 1ns / 1ps

module point_to_grid_binning_top import ptgb_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,   // cam_x, cam_y, cam_z, zero pad
  input  logic                in_tuser,   // point_valid
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [79:0]         out_tdata,  // cell_index, out_x, out_y, out_z, zero pad
  output logic [StatusW-1:0]  out_tuser,  // status
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  ptgb_cfg_t cfg;

  ptgb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ptgb_pipe #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> tb/tb_point_to_grid_binning_top.sv
`timescale 1ns / 1ps

module tb_point_to_grid_binning_top;
  import ptgb_pkg::*;

  localparam int GridW       = GRID_WIDTH_DEF;
  localparam int GridH       = GRID_HEIGHT_DEF;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 10;

  typedef struct {
    ptgb_status_t     status;
    logic [CellW-1:0] cell_idx;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } bin_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [63:0]         in_tdata;   // cam_x, cam_y, cam_z, zero pad
  logic                in_tuser;   // point_valid
  logic                out_tvalid;
  logic                out_tready;
  logic [79:0]         out_tdata;  // cell_index, out_x, out_y, out_z, zero pad
  logic [StatusW-1:0]  out_tuser;  // status
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  bin_result_t expected_bins[$];
  ptgb_cfg_t   grid_cfg;
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          no_idle = 1'b0;

  point_to_grid_binning_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Map coordinate in cells: exact dot product plus offset, scaled, floored once.
  function automatic longint map_coord(input logic [47:0] row, input logic signed [31:0] off,
                                       input longint px, input longint py, input longint pz);
    longint acc;
    acc = longint'($signed(row[15:0])) * px + longint'($signed(row[31:16])) * py
        + longint'($signed(row[47:32])) * pz + longint'(off) * 16384;
    acc = acc * longint'(grid_cfg.cells_per_meter);
    return acc >>> 32;
  endfunction

  function automatic bin_result_t bin_point(input logic pv, input logic signed [CoordW-1:0] x,
                                            input logic signed [CoordW-1:0] y,
                                            input logic signed [CoordW-1:0] z);
    bin_result_t r;
    longint px, py, pz, range_sq, gx, gy;
    px = x;
    py = y;
    pz = z;
    range_sq = px * px + py * py + pz * pz;
    r.status = ST_BINNED;
    r.cell_idx = '0;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    if (!pv) begin
      r.status = ST_INVALID;
    end else if (range_sq < longint'(grid_cfg.near_clip_sq)) begin
      r.status = ST_NEAR;
    end else if (range_sq > longint'(grid_cfg.far_clip_sq)) begin
      r.status = ST_FAR;
    end else begin
      gx = map_coord(grid_cfg.rot_x, grid_cfg.offset_x, px, py, pz);
      gy = map_coord(grid_cfg.rot_y, grid_cfg.offset_y, px, py, pz);
      if (gx < 0 || gx >= GridW || gy < 0 || gy >= GridH) begin
        r.status = ST_OUTSIDE;
      end else begin
        r.cell_idx = CellW'(gy * GridW + gx);
        r.x = x;
        r.y = y;
        r.z = z;
      end
    end
    return r;
  endfunction

  function automatic logic [CoordW-1:0] rand_coord(input int span);
    return CoordW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Valid is left high after a request so that back-to-back requests need no toggle.
  task automatic send_point(input logic pv, input logic [CoordW-1:0] x,
                            input logic [CoordW-1:0] y, input logic [CoordW-1:0] z);
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= pv;
    in_tdata <= {4'b0, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_bins.push_back(bin_point(pv, x, y, z));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input ptgb_reg_t idx, input logic [CfgDataW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CfgAddrW'({idx, 3'b000});
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_ROT_X:    grid_cfg.rot_x = value[47:0];
      REG_ROT_Y:    grid_cfg.rot_y = value[47:0];
      REG_OFFSET_X: grid_cfg.offset_x = value[31:0];
      REG_OFFSET_Y: grid_cfg.offset_y = value[31:0];
      REG_CPM:      grid_cfg.cells_per_meter = value[15:0];
      REG_NEAR:     grid_cfg.near_clip_sq = value[39:0];
      REG_FAR:      grid_cfg.far_clip_sq = value[39:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Most settings put the camera origin near the grid center so that points bin;
  // the wild ones load every register with raw random bits.
  task automatic set_random_setup(input bit wild, output int span);
    int center;
    logic [15:0] cpm;
    logic [47:0] rot [2];
    longint span_sq;
    if (wild) begin
      write_reg(REG_ROT_X, {$urandom, $urandom});
      write_reg(REG_ROT_Y, {$urandom, $urandom});
      write_reg(REG_OFFSET_X, {$urandom, $urandom});
      write_reg(REG_OFFSET_Y, {$urandom, $urandom});
      write_reg(REG_CPM, {$urandom, $urandom});
      write_reg(REG_NEAR, {$urandom, $urandom});
      write_reg(REG_FAR, {$urandom, $urandom});
      span = $urandom_range(1000, 524287);
    end else begin
      cpm = 16'($urandom_range(128, 2048));
      center = 16777216 / cpm;
      span = center / 3;
      span_sq = longint'(span) * span;
      for (int r = 0; r < 2; r++) begin
        for (int k = 0; k < 3; k++) begin
          rot[r][16*k +: 16] = 16'($urandom_range(0, 32768) - 16384);
        end
      end
      write_reg(REG_ROT_X, 64'(rot[0]));
      write_reg(REG_ROT_Y, 64'(rot[1]));
      write_reg(REG_OFFSET_X, 64'(32'(center + int'($urandom_range(0, center / 2)) - center / 4)));
      write_reg(REG_OFFSET_Y, 64'(32'(center + int'($urandom_range(0, center / 2)) - center / 4)));
      write_reg(REG_CPM, 64'(cpm));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_NEAR, '0);
        write_reg(REG_FAR, 64'(FAR_RST));
      end else begin
        write_reg(REG_NEAR, 64'(span_sq / $urandom_range(16, 256)));
        write_reg(REG_FAR, 64'(span_sq * $urandom_range(1, 3)));
      end
    end
  endtask

  // With the reset rotation, cam_y drives the column and cam_x the row at two cells per meter.
  task automatic test_reset_defaults();
    send_point(1'b0, -524288, 524287, -524288);
    send_point(1'b1, 0, 0, 0);
    send_point(1'b1, 524287, 524287, 524287);
    send_point(1'b1, -524288, -524288, -524288);
    send_point(1'b1, 65535, 32767, 7);
    send_point(1'b1, 0, 65535, 0);
    send_point(1'b1, 0, 65536, 0);
    send_point(1'b1, 0, -1, 0);
    send_point(1'b1, 511, 511, -3000);
    wait_idle();
  endtask

  task automatic test_clip_edges();
    write_reg(REG_NEAR, 64'd1000);
    write_reg(REG_FAR, 64'd5000);
    send_point(1'b0, 10, 30, 0);
    send_point(1'b1, 10, 30, 0);
    send_point(1'b1, 10, 29, 0);
    send_point(1'b1, 50, 50, 0);
    send_point(1'b1, 50, 50, 1);
    wait_idle();
    // Near clip above far clip.
    write_reg(REG_NEAR, 64'd5000);
    write_reg(REG_FAR, 64'd1000);
    send_point(1'b1, 10, 0, 0);
    send_point(1'b1, 80, 0, 0);
    wait_idle();
  endtask

  task automatic test_extreme_settings();
    write_reg(REG_ROT_X, 64'h0000_7FFF_8000_7FFF);
    write_reg(REG_ROT_Y, 64'h0000_8000_7FFF_8000);
    write_reg(REG_OFFSET_X, 64'h0000_0000_7FFF_FFFF);
    write_reg(REG_OFFSET_Y, 64'h0000_0000_8000_0000);
    write_reg(REG_CPM, '0);
    write_reg(REG_NEAR, '0);
    write_reg(REG_FAR, 64'(FAR_RST));
    // Zero scale folds every kept point into the first cell.
    send_point(1'b1, 524287, -524288, 524287);
    send_point(1'b1, -524288, 524287, -524288);
    wait_idle();
    write_reg(REG_ROT_X, 64'(ROT_X_RST));
    write_reg(REG_ROT_Y, 64'(ROT_Y_RST));
    write_reg(REG_OFFSET_X, '0);
    write_reg(REG_OFFSET_Y, '0);
    write_reg(REG_CPM, 64'hFFFF);
    write_reg(REG_NONE, '1);
    send_point(1'b1, 300, 100, 0);
    wait_idle();
    write_reg(REG_OFFSET_X, 64'h0000_0000_FFFF_FFFF);
    send_point(1'b1, 300, 0, 0);
    send_point(1'b1, 300, 64, 0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int span;
    int pick;
    for (int phase = 0; phase < 10; phase++) begin
      set_random_setup(phase == 7 || $urandom_range(0, 4) == 0, span);
      no_idle = (phase == 3);
      for (int n = 0; n < 95; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_point(1'b1, rand_coord(span), rand_coord(span), rand_coord(span));
        end else if (pick < 88) begin
          send_point(1'b0, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
        end else begin
          send_point(1'($urandom), CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
        end
      end
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bins.size() == 0) begin
        $error("unexpected result: status %0d, cell_index %0d", out_tuser, out_tdata[13:0]);
        mismatches++;
      end else begin
        want = expected_bins.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[13:0] !== want.cell_idx) begin
          $error("cell_index: expected %0d, actual %0d", want.cell_idx, out_tdata[13:0]);
          mismatches++;
        end
        if (out_tdata[33:14] !== want.x) begin
          $error("out_x: expected %0d, actual %0d", $signed(want.x), $signed(out_tdata[33:14]));
          mismatches++;
        end
        if (out_tdata[53:34] !== want.y) begin
          $error("out_y: expected %0d, actual %0d", $signed(want.y), $signed(out_tdata[53:34]));
          mismatches++;
        end
        if (out_tdata[73:54] !== want.z) begin
          $error("out_z: expected %0d, actual %0d", $signed(want.z), $signed(out_tdata[73:54]));
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("** point_to_grid_binning_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    grid_cfg.rot_x = ROT_X_RST;
    grid_cfg.rot_y = ROT_Y_RST;
    grid_cfg.offset_x = '0;
    grid_cfg.offset_y = '0;
    grid_cfg.cells_per_meter = CPM_RST;
    grid_cfg.near_clip_sq = '0;
    grid_cfg.far_clip_sq = FAR_RST;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_clip_edges();
    test_extreme_settings();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("** point_to_grid_binning_top: PASSED **");
    end else begin
      $display("** point_to_grid_binning_top: FAILED **");
    end
    $finish;
  end

endmodule
